/* rtl/wtst_pkg.sv */
// Package for the windowed trade statistics table.
// Holds the table size, field widths, the entry record type and the FSM states.
`timescale 1ns / 1ps

package wtst_pkg;

   // table size and index width
   localparam int SYMBOLS = 32;
   localparam int IDX_W   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

   localparam int TIME_W  = 48;
   localparam int WIN_W   = 27;
   localparam int CNT_W   = 32;
   localparam int VOL_W   = 63;
   localparam int PRICE_W = 32;
   localparam int DIV_CNT_W = $clog2(TIME_W);

   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1000);
   localparam logic [VOL_W-1:0] VOL_MAX      = {VOL_W{1'b1}};
   localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};

   // register index of the window length
   localparam logic REG_WINDOW = 1'b0;

   // one table entry
   typedef struct packed {
      logic                seen;
      logic [TIME_W-1:0]   recorded_window;
      logic [TIME_W-1:0]   entry_window;
      logic [CNT_W-1:0]    count;
      logic [VOL_W-1:0]    volume;
      logic [PRICE_W-1:0]  low_price;
      logic [PRICE_W-1:0]  high_price;
      logic [CNT_W-1:0]    sell;
      logic [CNT_W-1:0]    buy;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{
      seen:            1'b0,
      recorded_window: '0,
      entry_window:    '0,
      count:           '0,
      volume:          '0,
      low_price:       '1,
      high_price:      '0,
      sell:            '0,
      buy:             '0
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_UPD,
      ST_SCAN,
      ST_FL_RD
   } state_type;

   localparam logic REQ_TRADE = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

endpackage

/* rtl/wtst_if.sv */
// Valid/ready channel interfaces for trade requests and statistics reports.
// Depends on nothing.
`timescale 1ns / 1ps

interface wtst_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [4:0]  symbol_index;
   logic [31:0] price;
   logic [31:0] quantity;
   logic        buyer_is_maker;
   logic [47:0] exchange_time_ms;

   modport source (output valid, req_type, symbol_index, price, quantity,
                   buyer_is_maker, exchange_time_ms, input ready);
   modport sink   (input valid, req_type, symbol_index, price, quantity,
                   buyer_is_maker, exchange_time_ms, output ready);
endinterface

interface wtst_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  out_symbol;
   logic [47:0] window_start_ms;
   logic [31:0] trade_count;
   logic [62:0] total_volume;
   logic [31:0] min_price;
   logic [31:0] max_price;
   logic [31:0] seller_count;
   logic [31:0] buyer_count;
   logic        last;

   modport source (output valid, out_symbol, window_start_ms, trade_count,
                   total_volume, min_price, max_price, seller_count,
                   buyer_count, last, input ready);
   modport sink   (input valid, out_symbol, window_start_ms, trade_count,
                   total_volume, min_price, max_price, seller_count,
                   buyer_count, last, output ready);
endinterface

/* rtl/windowed_trade_stats_table.sv */
// Windowed trade statistics table, top level. Uses wtst_pkg and wtst_if.
// Trade: accepted in ST_IDLE, then bit-serial restoring division in ST_DIV
// (window start), then the entry update in ST_UPD; no new request is taken meanwhile.
// Flush: accepted in ST_IDLE, then ST_SCAN walks the entries and ST_FL_RD reads and
// reports each entry holding trades; a report waits until the previous one is taken.
// Reset (synchronous): window 1000 ms, all entries invalid (read as cleared).
`timescale 1ns / 1ps

module windowed_trade_stats_table
   import wtst_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   wtst_req_if.sink          req_if,
   wtst_rsp_if.source        rsp_if,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   // entry memory, registered read
   entry_type              mem [SYMBOLS];
   entry_type              rd_ff;
   logic                   rd_vld_ff;
   logic [SYMBOLS-1:0]     valid_ff, valid_in;
   logic [SYMBOLS-1:0]     nz_ff, nz_in;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   entry_type              wr_data;

   state_type              state_ff, state_in;
   logic [WIN_W-1:0]       window_ff;
   logic [WIN_W-1:0]       win;

   // registered trade word
   logic [IDX_W-1:0]       sym_ff;
   logic [PRICE_W-1:0]     price_ff;
   logic [31:0]            qty_ff;
   logic                   maker_ff;
   logic [TIME_W-1:0]      time_ff;
   logic [TIME_W-1:0]      dividend_ff;
   logic [WIN_W:0]         rem_ff;
   logic [DIV_CNT_W-1:0]   div_cnt_ff;
   logic [63:0]            prod_ff;
   logic [IDX_W-1:0]       scan_ff, scan_in;

   // output register
   logic                   rsp_vld_ff, rsp_vld_in;
   logic                   rsp_load;
   logic                   more;

   entry_type              cur, base, upd, flushed;
   logic [TIME_W-1:0]      start;
   logic [VOL_W-1:0]       prod_sat;
   logic [VOL_W:0]         vol_sum;
   logic [WIN_W:0]         rem_shift;
   logic                   req_accept;

   assign win = (window_ff == '0) ? WIN_W'(1) : window_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_WINDOW) ? {5'b0, window_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_WINDOW) begin
         window_ff <= csr_pwdata[WIN_W-1:0];
      end
   end

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;

   // memory read and write
   assign rd_addr = (state_ff == ST_SCAN || state_ff == ST_FL_RD) ? scan_ff : sym_ff;

   always_ff @(posedge clock) begin
      rd_ff     <= mem[rd_addr];
      rd_vld_ff <= valid_ff[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign cur = rd_vld_ff ? rd_ff : ENTRY_RESET;

   // trade update of one entry
   assign start    = time_ff - TIME_W'(rem_ff);
   assign prod_sat = prod_ff[63] ? VOL_MAX : prod_ff[VOL_W-1:0];

   always_comb begin
      base = cur;
      if (!cur.seen || cur.recorded_window != start) begin
         base              = ENTRY_RESET;
         base.entry_window = start;
      end
      base.seen            = 1'b1;
      base.recorded_window = start;
      upd       = base;
      upd.count = (base.count == CNT_MAX) ? CNT_MAX : base.count + 1'b1;
      vol_sum   = {1'b0, base.volume} + {1'b0, prod_sat};
      upd.volume = (vol_sum > {1'b0, VOL_MAX}) ? VOL_MAX : vol_sum[VOL_W-1:0];
      if (price_ff < base.low_price) begin
         upd.low_price = price_ff;
      end
      if (price_ff > base.high_price) begin
         upd.high_price = price_ff;
      end
      if (maker_ff) begin
         upd.sell = (base.sell == CNT_MAX) ? CNT_MAX : base.sell + 1'b1;
      end else begin
         upd.buy = (base.buy == CNT_MAX) ? CNT_MAX : base.buy + 1'b1;
      end
   end

   // flushed entry: cleared, window advanced
   always_comb begin
      flushed                 = ENTRY_RESET;
      flushed.seen            = cur.seen;
      flushed.recorded_window = cur.recorded_window;
      flushed.entry_window    = cur.entry_window + TIME_W'(win);
   end

   // any entry above the scan position still holding trades
   always_comb begin
      more = 1'b0;
      for (int j = 0; j < SYMBOLS; j++) begin
         if (j > int'(scan_ff) && nz_ff[j]) begin
            more = 1'b1;
         end
      end
   end

   // one restoring division step
   assign rem_shift = {rem_ff[WIN_W-1:0], dividend_ff[TIME_W-1]};

   // control
   always_comb begin
      state_in   = state_ff;
      scan_in    = scan_ff;
      valid_in   = valid_ff;
      nz_in      = nz_ff;
      wr_en      = 1'b0;
      wr_addr    = sym_ff;
      wr_data    = upd;
      rsp_load   = 1'b0;
      rsp_vld_in = rsp_vld_ff && !rsp_if.ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_if.req_type == REQ_FLUSH) begin
                  state_in = ST_SCAN;
                  scan_in  = '0;
               end else if (32'(req_if.symbol_index) < SYMBOLS) begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_cnt_ff == DIV_CNT_W'(TIME_W - 1)) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            wr_en            = 1'b1;
            valid_in[sym_ff] = 1'b1;
            nz_in[sym_ff]    = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_SCAN: begin
            if (nz_ff[scan_ff]) begin
               if (!rsp_vld_ff || rsp_if.ready) begin
                  state_in = ST_FL_RD;
               end
            end else if (32'(scan_ff) == SYMBOLS - 1) begin
               state_in = ST_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_FL_RD: begin
            wr_en             = 1'b1;
            wr_addr           = scan_ff;
            wr_data           = flushed;
            valid_in[scan_ff] = 1'b1;
            nz_in[scan_ff]    = 1'b0;
            rsp_load          = 1'b1;
            rsp_vld_in        = 1'b1;
            if (32'(scan_ff) == SYMBOLS - 1) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SCAN;
               scan_in  = scan_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         nz_ff      <= '0;
         rsp_vld_ff <= 1'b0;
         scan_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         nz_ff      <= nz_in;
         rsp_vld_ff <= rsp_vld_in;
         scan_ff    <= scan_in;
      end
   end

   // trade word capture and divider datapath
   always_ff @(posedge clock) begin
      if (req_accept) begin
         sym_ff      <= IDX_W'(req_if.symbol_index);
         price_ff    <= req_if.price;
         qty_ff      <= req_if.quantity;
         maker_ff    <= req_if.buyer_is_maker;
         time_ff     <= req_if.exchange_time_ms;
         dividend_ff <= req_if.exchange_time_ms;
         rem_ff      <= '0;
         div_cnt_ff  <= '0;
      end else if (state_ff == ST_DIV) begin
         prod_ff     <= 64'(price_ff) * 64'(qty_ff);
         dividend_ff <= {dividend_ff[TIME_W-2:0], 1'b0};
         div_cnt_ff  <= div_cnt_ff + 1'b1;
         if (rem_shift >= {1'b0, win}) begin
            rem_ff <= rem_shift - {1'b0, win};
         end else begin
            rem_ff <= rem_shift;
         end
      end
   end

   // report register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_if.out_symbol      <= 5'(scan_ff);
         rsp_if.window_start_ms <= cur.entry_window;
         rsp_if.trade_count     <= cur.count;
         rsp_if.total_volume    <= cur.volume;
         rsp_if.min_price       <= cur.low_price;
         rsp_if.max_price       <= cur.high_price;
         rsp_if.seller_count    <= cur.sell;
         rsp_if.buyer_count     <= cur.buy;
         rsp_if.last            <= !more;
      end
   end

   assign rsp_if.valid = rsp_vld_ff;

endmodule
